@@ hw/rtl/cnms_pkg.sv @@
// Shared types, constants and calendar helpers of the cron next-match search.
`default_nettype none

package cnms_pkg;

    // Default horizon in years
    localparam int SEARCH_YEARS_DEF = 1;

    // Clamp bounds of the start instant
    localparam logic [13:0] YEAR_MIN = 14'd1970;
    localparam logic [13:0] YEAR_MAX = 14'd9970;

    // Rule encoding: bits 7-6 mode, bits 5-0 value or step
    localparam logic [1:0] MODE_ANY    = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_STEP   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_MINUTE  = 3'd0;
    localparam logic [2:0] REG_HOUR    = 3'd1;
    localparam logic [2:0] REG_DAY     = 3'd2;
    localparam logic [2:0] REG_MONTH   = 3'd3;
    localparam logic [2:0] REG_WEEKDAY = 3'd4;

    // Reciprocals: floor(y/100) = (y*5243)>>19, floor(s/7) = (s*18725)>>17
    localparam logic [14:0] MUL_DIV100 = 15'd5243;
    localparam logic [14:0] MUL_DIV7   = 15'd18725;

    // Input item
    typedef struct packed {
        logic [13:0] start_year;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
        logic [4:0]  start_hour;
        logic [5:0]  start_minute;
    } t_in;

    // Result item
    typedef struct packed {
        logic        found;
        logic [13:0] next_year;
        logic [3:0]  next_month;
        logic [4:0]  next_day;
        logic [4:0]  next_hour;
        logic [5:0]  next_minute;
        logic [2:0]  next_weekday;
    } t_out;

    // Residue counter control for one field unit
    typedef struct packed {
        logic clr;
        logic inc;
    } t_res_ctl;

    // Rule is usable for a field with range lo..hi
    function automatic logic rule_valid(input logic [7:0] rule, input logic [5:0] lo,
                                        input logic [5:0] hi);
        logic ok;
        ok = 1'b0;
        case (rule[7:6])
            MODE_ANY:    ok = 1'b1;
            MODE_SINGLE: ok = (rule[5:0] >= lo) && (rule[5:0] <= hi);
            MODE_STEP:   ok = (rule[5:0] != 6'd0);
            default:     ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Days in month m (1..12) of a year with the given leap flag
    function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
        logic [4:0] n;
        case (m)
            4'd2:                      n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    // Month offset of the weekday formula
    function automatic logic [2:0] sak_off(input logic [3:0] m);
        logic [2:0] o;
        case (m)
            4'd1:    o = 3'd0;
            4'd2:    o = 3'd3;
            4'd3:    o = 3'd2;
            4'd4:    o = 3'd5;
            4'd5:    o = 3'd0;
            4'd6:    o = 3'd3;
            4'd7:    o = 3'd5;
            4'd8:    o = 3'd1;
            4'd9:    o = 3'd4;
            4'd10:   o = 3'd6;
            4'd11:   o = 3'd2;
            4'd12:   o = 3'd4;
            default: o = 3'd0;
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cnms_field.sv @@
// One calendar field rule: residue counter for step rules and the hit decision.
`default_nettype none

module cnms_field (
    input  wire logic               i_clk,
    input  wire logic [7:0]         i_rule,
    input  wire logic [5:0]         i_value,
    input  wire cnms_pkg::t_res_ctl i_ctl,
    output logic                    o_hit
);

    // (value - field minimum) mod step, tracked as the value steps up by one
    logic [5:0] r_res;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_res <= 6'd0;
        end else if (i_ctl.inc) begin
            r_res <= ((r_res + 6'd1) == i_rule[5:0]) ? 6'd0 : (r_res + 6'd1);
        end
    end

    // Hit per mode; invalid rules are rejected before any search
    always_comb begin
        case (i_rule[7:6])
            cnms_pkg::MODE_ANY:    o_hit = 1'b1;
            cnms_pkg::MODE_SINGLE: o_hit = (i_value == i_rule[5:0]);
            cnms_pkg::MODE_STEP:   o_hit = (r_res == 6'd0);
            default:               o_hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/cron_next_match_search_core.sv @@
// Top level of the cron next-match search: sequencer, calendar walk and result register.
//
// Usage: write the five rules on the configuration port (index 0 minute, 1 hour,
// 2 day of month, 3 month, 4 weekday) while the block is idle. An input item
// carries a UTC start instant; the result item carries the earliest later minute
// that matches all five rules, or found = 0 with all fields zero.
// Both channels use valid/stall; o_in_stall is high while an item is being searched,
// so one item is in work at a time. A finished result sits in an output register
// and the next item can be taken while it waits on i_out_stall.
// Setup computes the leap flag, then the weekday through one shared multiplier,
// then presets the residues. Each day walked passes a day check and an advance;
// a new year recomputes the leap flag first. Inside a matching day the hours,
// then the minutes are scanned one by one. A single-month rule may walk up to
// 366 days; SEARCH_YEARS*366+1 days bound the walk. Invalid rules skip the search.
// Reset clears all rules to "any" and drops any pending result. While the receiver
// stalls, the result holds and the block finishes its search but will not overwrite it.
`default_nettype none

module cron_next_match_search_core #(
    parameter int SEARCH_YEARS = cnms_pkg::SEARCH_YEARS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // input channel
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire cnms_pkg::t_in  i_in,
    // output channel
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output cnms_pkg::t_out      o_out,
    // configuration
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_idx,
    input  wire logic [7:0]     i_cfg_data
);

    localparam int LIMIT = SEARCH_YEARS * 366;
    localparam int OFF_W = $clog2(LIMIT + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LEAP1, S_LEAP2, S_CLAMPD, S_WD1, S_WD2, S_WD3, S_WD4,
        S_RINIT, S_DAY, S_HOUR, S_MIN, S_ADV, S_DONE
    } t_state;

    t_state          r_state;
    logic [7:0]      r_min_rule, r_hour_rule, r_day_rule, r_mon_rule, r_wd_rule;
    logic [13:0]     r_y;
    logic [3:0]      r_m;
    logic [4:0]      r_d;
    logic [2:0]      r_wd;
    logic [4:0]      r_hh;
    logic [5:0]      r_mm;
    logic [4:0]      r_hstart;
    logic [5:0]      r_mstart0;
    logic [5:0]      r_mbeg;
    logic [OFF_W-1:0] r_off;
    logic [4:0]      r_cnt;
    logic [29:0]     r_prod;
    logic [14:0]     r_s;
    logic            r_leap;
    logic            r_init;
    logic            r_found;
    logic            r_out_valid;
    cnms_pkg::t_out  r_out;

    // Input clamps and rule check
    logic [13:0] cl_y;
    logic [3:0]  cl_m;
    logic [4:0]  cl_h;
    logic [5:0]  cl_mi;
    logic        rules_ok;
    logic        in_acc;

    // Shared multiplier operands
    logic [14:0] mul_a, mul_k;
    logic [13:0] yy;
    logic [7:0]  q100;
    logic [12:0] q7;
    logic [14:0] r7;
    logic [4:0]  dim;

    // Field hits and decisions
    logic hit_mi, hit_h, hit_d, hit_mo, hit_wd;
    logic day_pass, hour_take, min_take;
    logic d_wrap, m_wrap;
    cnms_pkg::t_res_ctl ctl_mi, ctl_h, ctl_d, ctl_mo, ctl_wd;

    assign in_acc = i_in_valid && (r_state == S_IDLE);

    // Clamp start fields and check the rule set
    always_comb begin
        cl_y = i_in.start_year;
        if (cl_y < cnms_pkg::YEAR_MIN) cl_y = cnms_pkg::YEAR_MIN;
        if (cl_y > cnms_pkg::YEAR_MAX) cl_y = cnms_pkg::YEAR_MAX;
        cl_m = i_in.start_month;
        if (cl_m == 4'd0) cl_m = 4'd1;
        if (cl_m > 4'd12) cl_m = 4'd12;
        cl_h  = (i_in.start_hour > 5'd23) ? 5'd23 : i_in.start_hour;
        cl_mi = (i_in.start_minute > 6'd59) ? 6'd59 : i_in.start_minute;
        rules_ok = cnms_pkg::rule_valid(r_min_rule, 6'd0, 6'd59) &&
                   cnms_pkg::rule_valid(r_hour_rule, 6'd0, 6'd23) &&
                   cnms_pkg::rule_valid(r_day_rule, 6'd1, 6'd31) &&
                   cnms_pkg::rule_valid(r_mon_rule, 6'd1, 6'd12) &&
                   cnms_pkg::rule_valid(r_wd_rule, 6'd0, 6'd6);
    end

    // Multiplier operand select and product slices
    always_comb begin
        yy = r_y - {13'd0, (r_m < 4'd3)};
        mul_a = {1'b0, r_y};
        mul_k = cnms_pkg::MUL_DIV100;
        case (r_state)
            S_WD1: mul_a = {1'b0, yy};
            S_WD3: begin
                mul_a = r_s;
                mul_k = cnms_pkg::MUL_DIV7;
            end
            default: mul_a = {1'b0, r_y};
        endcase
        q100 = r_prod[26:19];
        q7   = r_prod[29:17];
        r7   = r_s - ({2'b0, q7} * 15'd7);
        dim  = cnms_pkg::month_days(r_leap, r_m);
    end

    // Field rule units
    cnms_field u_min (.i_clk(i_clk), .i_rule(r_min_rule), .i_value(r_mm),
                      .i_ctl(ctl_mi), .o_hit(hit_mi));
    cnms_field u_hour (.i_clk(i_clk), .i_rule(r_hour_rule), .i_value({1'b0, r_hh}),
                       .i_ctl(ctl_h), .o_hit(hit_h));
    cnms_field u_day (.i_clk(i_clk), .i_rule(r_day_rule), .i_value({1'b0, r_d}),
                      .i_ctl(ctl_d), .o_hit(hit_d));
    cnms_field u_mon (.i_clk(i_clk), .i_rule(r_mon_rule), .i_value({2'b0, r_m}),
                      .i_ctl(ctl_mo), .o_hit(hit_mo));
    cnms_field u_wd (.i_clk(i_clk), .i_rule(r_wd_rule), .i_value({3'b0, r_wd}),
                     .i_ctl(ctl_wd), .o_hit(hit_wd));

    // Search decisions and residue control
    always_comb begin
        day_pass  = hit_d && hit_mo && hit_wd;
        hour_take = (r_hh >= r_hstart) && hit_h;
        min_take  = (r_mm >= r_mbeg) && hit_mi;
        d_wrap    = (r_d == dim);
        m_wrap    = (r_m == 4'd12);
        ctl_mi = '0;
        ctl_h  = '0;
        ctl_d  = '0;
        ctl_mo = '0;
        ctl_wd = '0;
        case (r_state)
            S_WD4: begin
                ctl_d.clr  = 1'b1;
                ctl_mo.clr = 1'b1;
                ctl_wd.clr = 1'b1;
            end
            S_RINIT: begin
                ctl_d.inc  = ({1'b0, r_cnt} + 6'd1) < {1'b0, r_d};
                ctl_mo.inc = ({1'b0, r_cnt} + 6'd1) < {2'b0, r_m};
                ctl_wd.inc = r_cnt < {2'b0, r_wd};
            end
            S_DAY: begin
                ctl_h.clr = day_pass;
            end
            S_HOUR: begin
                ctl_mi.clr = hour_take;
                ctl_h.inc  = !hour_take && (r_hh != 5'd23);
            end
            S_MIN: begin
                ctl_mi.inc = !min_take && (r_mm != 6'd59);
                ctl_h.inc  = !min_take && (r_mm == 6'd59) && (r_hh != 5'd23);
            end
            S_ADV: begin
                if (r_off != OFF_W'(LIMIT)) begin
                    ctl_d.clr  = d_wrap;
                    ctl_d.inc  = !d_wrap;
                    ctl_mo.clr = d_wrap && m_wrap;
                    ctl_mo.inc = d_wrap && !m_wrap;
                    ctl_wd.clr = (r_wd == 3'd6);
                    ctl_wd.inc = (r_wd != 3'd6);
                end
            end
            default: ctl_mi = '0;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rule  <= 8'd0;
            r_hour_rule <= 8'd0;
            r_day_rule  <= 8'd0;
            r_mon_rule  <= 8'd0;
            r_wd_rule   <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cnms_pkg::REG_MINUTE:  r_min_rule  <= i_cfg_data;
                cnms_pkg::REG_HOUR:    r_hour_rule <= i_cfg_data;
                cnms_pkg::REG_DAY:     r_day_rule  <= i_cfg_data;
                cnms_pkg::REG_MONTH:   r_mon_rule  <= i_cfg_data;
                cnms_pkg::REG_WEEKDAY: r_wd_rule   <= i_cfg_data;
                default:               r_min_rule  <= r_min_rule;
            endcase
        end
    end

    // Sequencer, calendar walk and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_init      <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            // result taken; a new one loaded in S_DONE keeps valid up
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_y       <= cl_y;
                        r_m       <= cl_m;
                        r_d       <= i_in.start_day;
                        r_hstart  <= (cl_mi == 6'd59) ? (cl_h + 5'd1) : cl_h;
                        r_mstart0 <= (cl_mi == 6'd59) ? 6'd0 : (cl_mi + 6'd1);
                        r_init    <= 1'b1;
                        r_found   <= 1'b0;
                        r_state   <= rules_ok ? S_LEAP1 : S_DONE;
                    end
                end
                S_LEAP1: begin
                    r_prod  <= {15'd0, mul_a} * {15'd0, mul_k};
                    r_state <= S_LEAP2;
                end
                S_LEAP2: begin
                    r_leap  <= (r_y[1:0] == 2'b00) &&
                               ((({7'd0, q100} * 15'd100) != {1'b0, r_y}) ||
                                (q100[1:0] == 2'b00));
                    r_state <= r_init ? S_CLAMPD : S_DAY;
                end
                S_CLAMPD: begin
                    if (r_d == 5'd0) begin
                        r_d <= 5'd1;
                    end else if (r_d > dim) begin
                        r_d <= dim;
                    end
                    r_state <= S_WD1;
                end
                S_WD1: begin
                    r_prod  <= {15'd0, mul_a} * {15'd0, mul_k};
                    r_state <= S_WD2;
                end
                S_WD2: begin
                    r_s <= {1'b0, yy} + {3'd0, yy[13:2]} - {7'd0, q100} +
                           {9'd0, q100[7:2]} + {12'd0, cnms_pkg::sak_off(r_m)} +
                           {10'd0, r_d};
                    r_state <= S_WD3;
                end
                S_WD3: begin
                    r_prod  <= {15'd0, mul_a} * {15'd0, mul_k};
                    r_state <= S_WD4;
                end
                S_WD4: begin
                    // Sunday-based remainder to Monday-based weekday
                    r_wd    <= (r7[2:0] == 3'd0) ? 3'd6 : (r7[2:0] - 3'd1);
                    r_cnt   <= 5'd0;
                    r_state <= S_RINIT;
                end
                S_RINIT: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_off   <= '0;
                        r_init  <= 1'b0;
                        r_state <= S_DAY;
                    end
                end
                S_DAY: begin
                    if (day_pass) begin
                        r_hh    <= 5'd0;
                        r_state <= S_HOUR;
                    end else begin
                        r_state <= S_ADV;
                    end
                end
                S_HOUR: begin
                    if (hour_take) begin
                        r_mm    <= 6'd0;
                        r_mbeg  <= (r_hh == r_hstart) ? r_mstart0 : 6'd0;
                        r_state <= S_MIN;
                    end else if (r_hh == 5'd23) begin
                        r_state <= S_ADV;
                    end else begin
                        r_hh <= r_hh + 5'd1;
                    end
                end
                S_MIN: begin
                    if (min_take) begin
                        r_found <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_mm != 6'd59) begin
                        r_mm <= r_mm + 6'd1;
                    end else if (r_hh == 5'd23) begin
                        r_state <= S_ADV;
                    end else begin
                        r_hh    <= r_hh + 5'd1;
                        r_state <= S_HOUR;
                    end
                end
                S_ADV: begin
                    if (r_off == OFF_W'(LIMIT)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_off     <= r_off + 1'b1;
                        r_hstart  <= 5'd0;
                        r_mstart0 <= 6'd0;
                        r_wd      <= (r_wd == 3'd6) ? 3'd0 : (r_wd + 3'd1);
                        // a new year needs its leap flag first
                        r_state   <= (d_wrap && m_wrap) ? S_LEAP1 : S_DAY;
                        if (d_wrap) begin
                            r_d <= 5'd1;
                            if (m_wrap) begin
                                r_m <= 4'd1;
                                r_y <= r_y + 14'd1;
                            end else begin
                                r_m <= r_m + 4'd1;
                            end
                        end else begin
                            r_d <= r_d + 5'd1;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        if (r_found) begin
                            r_out <= {1'b1, r_y, r_m, r_d, r_hh, r_mm, r_wd};
                        end else begin
                            r_out <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/cnms_chk.sv @@
// Port-level checks of the cron next-match search core, bound to the top level.
`default_nettype none

module cnms_chk (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           i_in_stall,
    input wire logic           i_out_valid,
    input wire logic           i_out_stall,
    input wire cnms_pkg::t_out i_out
);

    // A held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out))
        else $error("result changed while stalled");

    // One item at a time: taking an item closes the input
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("input open right after an item was taken");

    // A miss carries all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out.found |->
            i_out.next_year == 14'd0 && i_out.next_month == 4'd0 &&
            i_out.next_day == 5'd0 && i_out.next_hour == 5'd0 &&
            i_out.next_minute == 6'd0 && i_out.next_weekday == 3'd0)
        else $error("miss result with nonzero fields");

    // A match is a real calendar minute
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.found |->
            i_out.next_month >= 4'd1 && i_out.next_month <= 4'd12 &&
            i_out.next_day >= 5'd1 && i_out.next_hour <= 5'd23 &&
            i_out.next_minute <= 6'd59 && i_out.next_weekday <= 3'd6)
        else $error("match result out of calendar range");

endmodule

bind cron_next_match_search_core cnms_chk u_cnms_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out)
);

`default_nettype wire

@@ bench/cron_next_match_search_checker.sv @@
// Checker of the cron next-match search: tracks the rules, predicts every result and compares.
module cron_next_match_search_checker #(
    parameter int SEARCH_YEARS = cnms_pkg::SEARCH_YEARS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_stall,
    input  wire cnms_pkg::t_in  i_in,
    input  wire logic           i_out_valid,
    input  wire logic           i_out_stall,
    input  wire cnms_pkg::t_out i_out,
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_idx,
    input  wire logic [7:0]     i_cfg_data,
    output int                  o_pending,
    output int                  o_mismatches
);

    // Local copy of the five rules, indexed by register
    logic [7:0]     rules [0:4];
    cnms_pkg::t_out due_matches [$];
    cnms_pkg::t_out want;
    int             mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic bit is_leap(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_in(input int y, input int m);
        case (m)
            2:           return is_leap(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Monday = 0; counts days from 1970-01-01, which was a Thursday
    function automatic int weekday_of(input int y, input int m, input int d);
        int yy, yoe, doy, days;
        yy   = (m <= 2) ? y - 1 : y;
        yoe  = yy % 400;
        doy  = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
        days = (yy / 400) * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
        return (days + 3) % 7;
    endfunction

    function automatic bit rule_ok(input logic [7:0] r, input int lo, input int hi);
        int v;
        v = int'(r[5:0]);
        case (r[7:6])
            cnms_pkg::MODE_ANY:    return 1'b1;
            cnms_pkg::MODE_SINGLE: return (v >= lo) && (v <= hi);
            cnms_pkg::MODE_STEP:   return v != 0;
            default:               return 1'b0;
        endcase
    endfunction

    function automatic bit hits(input logic [7:0] r, input int lo, input int v);
        int p;
        p = int'(r[5:0]);
        case (r[7:6])
            cnms_pkg::MODE_ANY:    return 1'b1;
            cnms_pkg::MODE_SINGLE: return v == p;
            default:               return (p != 0) && ((v - lo) % p == 0);
        endcase
    endfunction

    // Walk day by day from the start minute; first matching hour and minute win
    function automatic cnms_pkg::t_out next_match(input cnms_pkg::t_in x);
        cnms_pkg::t_out r;
        int   y, mo, d, h, mi, wd, first, off, hh, mm;
        r = '0;
        if (!rule_ok(rules[cnms_pkg::REG_MINUTE], 0, 59) ||
            !rule_ok(rules[cnms_pkg::REG_HOUR], 0, 23) ||
            !rule_ok(rules[cnms_pkg::REG_DAY], 1, 31) ||
            !rule_ok(rules[cnms_pkg::REG_MONTH], 1, 12) ||
            !rule_ok(rules[cnms_pkg::REG_WEEKDAY], 0, 6))
            return r;
        y  = int'(x.start_year);
        mo = int'(x.start_month);
        d  = int'(x.start_day);
        h  = int'(x.start_hour);
        mi = int'(x.start_minute);
        if (y < 1970) y = 1970;
        if (y > 9970) y = 9970;
        if (mo < 1) mo = 1;
        if (mo > 12) mo = 12;
        if (d < 1) d = 1;
        if (d > days_in(y, mo)) d = days_in(y, mo);
        if (h > 23) h = 23;
        if (mi > 59) mi = 59;
        wd    = weekday_of(y, mo, d);
        first = h * 60 + mi + 1;
        for (off = 0; off <= SEARCH_YEARS * 366; off++) begin
            if (first < 1440 && hits(rules[cnms_pkg::REG_DAY], 1, d) &&
                hits(rules[cnms_pkg::REG_MONTH], 1, mo) &&
                hits(rules[cnms_pkg::REG_WEEKDAY], 0, wd)) begin
                for (hh = first / 60; hh < 24; hh++) begin
                    if (hits(rules[cnms_pkg::REG_HOUR], 0, hh)) begin
                        for (mm = (hh == first / 60) ? first % 60 : 0; mm < 60; mm++) begin
                            if (hits(rules[cnms_pkg::REG_MINUTE], 0, mm)) begin
                                r.found        = 1'b1;
                                r.next_year    = 14'(y);
                                r.next_month   = 4'(mo);
                                r.next_day     = 5'(d);
                                r.next_hour    = 5'(hh);
                                r.next_minute  = 6'(mm);
                                r.next_weekday = 3'(wd);
                                return r;
                            end
                        end
                    end
                end
            end
            first = 0;
            d++;
            if (d > days_in(y, mo)) begin
                d = 1;
                mo++;
                if (mo > 12) begin
                    mo = 1;
                    y++;
                end
            end
            wd = (wd + 1) % 7;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endtask

    // Track rule writes, queue predictions on accepted items, compare accepted results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= int'(cnms_pkg::REG_WEEKDAY); k++) rules[k] <= '0;
            due_matches.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we && i_cfg_idx <= cnms_pkg::REG_WEEKDAY) rules[i_cfg_idx] <= i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (due_matches.size() == 0) begin
                    mismatches++;
                    $display("%0t: unpredicted result found=%0d %0d-%0d-%0d %0d:%0d wd %0d",
                             $time, i_out.found, i_out.next_year, i_out.next_month,
                             i_out.next_day, i_out.next_hour, i_out.next_minute,
                             i_out.next_weekday);
                end else begin
                    want = due_matches.pop_front();
                    check_field("found", int'(want.found), int'(i_out.found));
                    check_field("next_year", int'(want.next_year), int'(i_out.next_year));
                    check_field("next_month", int'(want.next_month), int'(i_out.next_month));
                    check_field("next_day", int'(want.next_day), int'(i_out.next_day));
                    check_field("next_hour", int'(want.next_hour), int'(i_out.next_hour));
                    check_field("next_minute", int'(want.next_minute),
                                int'(i_out.next_minute));
                    check_field("next_weekday", int'(want.next_weekday),
                                int'(i_out.next_weekday));
                end
            end
            if (i_in_valid && !i_in_stall) due_matches.push_back(next_match(i_in));
            o_pending <= due_matches.size();
        end
    end

endmodule

@@ bench/cron_next_match_search_core_test.sv @@
// Testbench top of the cron next-match search: clock, reset, stimulus and verdict.
module cron_next_match_search_core_test;

    localparam int         CYCLE_LIMIT   = 5000000;
    localparam int         SETTLE_CYCLES = 700;
    localparam int         RANDOM_PHASES = 10;
    localparam int         PHASE_ITEMS   = 100;
    localparam logic [1:0] MODE_BAD      = 2'd3;
    localparam logic [7:0] ANY_RULE      = {cnms_pkg::MODE_ANY, 6'd0};

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    cnms_pkg::t_in  i_in;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    cnms_pkg::t_out o_out;
    logic           i_cfg_we;
    logic [2:0]     i_cfg_idx;
    logic [7:0]     i_cfg_data;

    int pending;
    int mismatches;
    int cycles  = 0;
    int rx_wait = 0;
    int rx_max  = 0;
    int rx_draw;
    int tx_max  = 10;

    cron_next_match_search_core #(
        .SEARCH_YEARS(cnms_pkg::SEARCH_YEARS_DEF)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    cron_next_match_search_checker #(
        .SEARCH_YEARS(cnms_pkg::SEARCH_YEARS_DEF)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_mismatches(mismatches)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: after each accepted item, stall for a random number of cycles
    always @(posedge i_clk) begin
        rx_draw = (o_out_valid && !i_out_stall) ? $urandom_range(0, rx_max) : rx_wait;
        i_out_stall <= (rx_draw != 0);
        rx_wait     <= (rx_draw != 0) ? rx_draw - 1 : 0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic cnms_pkg::t_in at(input int y, input int mo, input int d, input int h,
                                         input int mi);
        cnms_pkg::t_in s;
        s.start_year   = 14'(y);
        s.start_month  = 4'(mo);
        s.start_day    = 5'(d);
        s.start_hour   = 5'(h);
        s.start_minute = 6'(mi);
        return s;
    endfunction

    function automatic int tx_gap();
        return $urandom_range(0, tx_max);
    endfunction

    // Mostly sane rules; now and then a raw byte that may well be invalid
    function automatic logic [7:0] rand_rule(input int lo, input int hi);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 8) return {cnms_pkg::MODE_ANY, 6'($urandom)};
        if (pick < 13) return {cnms_pkg::MODE_SINGLE, 6'($urandom_range(lo, hi))};
        if (pick < 18) return {cnms_pkg::MODE_STEP, 6'($urandom_range(1, hi + 1))};
        if (pick < 19) return {cnms_pkg::MODE_STEP, 6'($urandom_range(1, 63))};
        return 8'($urandom);
    endfunction

    function automatic cnms_pkg::t_in rand_start();
        cnms_pkg::t_in s;
        int            pick;
        pick = $urandom_range(0, 9);
        s = at($urandom_range(1970, 9970), $urandom_range(1, 12), $urandom_range(1, 31),
               $urandom_range(0, 23), $urandom_range(0, 59));
        if (pick == 0) begin
            // raw field values, out of range ones included
            s = at($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 63));
        end else if (pick == 1) begin
            // last minute of a day near a month or year end
            s.start_day    = 5'($urandom_range(28, 31));
            s.start_hour   = 5'd23;
            s.start_minute = 6'd59;
            if ($urandom_range(0, 1) == 1) s.start_month = 4'd12;
        end
        return s;
    endfunction

    // Hold the item until the block takes it; valid stays up for a back-to-back item
    task automatic send(input cnms_pkg::t_in x, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= x;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // All five rules, optionally followed by a write to an unused index
    task automatic write_rules(input logic [7:0] mr, input logic [7:0] hr,
                               input logic [7:0] dr, input logic [7:0] nr,
                               input logic [7:0] wr, input bit stray);
        write_reg(cnms_pkg::REG_MINUTE, mr);
        write_reg(cnms_pkg::REG_HOUR, hr);
        write_reg(cnms_pkg::REG_DAY, dr);
        write_reg(cnms_pkg::REG_MONTH, nr);
        write_reg(cnms_pkg::REG_WEEKDAY, wr);
        if (stray) begin
            write_reg(cnms_pkg::REG_WEEKDAY + 3'($urandom_range(1, 3)), 8'($urandom));
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int p, k;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rx_max = 10;
        @(posedge i_clk);

        // Calendar corners and clamping with every rule at reset ("any")
        send(at(1970, 1, 1, 0, 0), tx_gap());
        send(at(9970, 12, 31, 23, 59), tx_gap());
        send(at(2023, 6, 15, 23, 59), tx_gap());
        send(at(2024, 2, 28, 23, 59), tx_gap());
        send(at(0, 1, 1, 0, 0), tx_gap());
        send(at(16383, 15, 31, 31, 63), tx_gap());
        send(at(2023, 0, 0, 12, 30), tx_gap());
        send(at(2023, 2, 31, 10, 10), tx_gap());
        send(at(2100, 2, 29, 23, 59), tx_gap());
        send(at(2000, 2, 29, 23, 59), tx_gap());
        send(at(2023, 4, 30, 23, 59), tx_gap());
        drain();

        // Single values at the top of every range: Sunday Dec 31, 23:59
        write_rules({cnms_pkg::MODE_SINGLE, 6'd59}, {cnms_pkg::MODE_SINGLE, 6'd23},
                    {cnms_pkg::MODE_SINGLE, 6'd31}, {cnms_pkg::MODE_SINGLE, 6'd12},
                    {cnms_pkg::MODE_SINGLE, 6'd6}, 1'b0);
        send(at(2023, 1, 1, 0, 0), tx_gap());
        send(at(2024, 1, 1, 0, 0), tx_gap());
        drain();

        // Steps, largest and smallest
        write_rules({cnms_pkg::MODE_STEP, 6'd63}, {cnms_pkg::MODE_STEP, 6'd1},
                    {cnms_pkg::MODE_STEP, 6'd2}, {cnms_pkg::MODE_STEP, 6'd5},
                    {cnms_pkg::MODE_STEP, 6'd3}, 1'b1);
        send(at(2023, 7, 20, 13, 45), tx_gap());
        send(at(1999, 12, 31, 23, 59), tx_gap());
        drain();

        // Invalid rules: reserved mode, single out of range, zero step
        write_rules({MODE_BAD, 6'h3F}, ANY_RULE, ANY_RULE, ANY_RULE, ANY_RULE, 1'b0);
        send(at(2023, 5, 5, 5, 5), tx_gap());
        drain();
        write_rules(ANY_RULE, {cnms_pkg::MODE_SINGLE, 6'd24}, ANY_RULE, ANY_RULE, ANY_RULE,
                    1'b0);
        send(at(2023, 5, 5, 5, 5), tx_gap());
        drain();
        write_rules(ANY_RULE, ANY_RULE, {cnms_pkg::MODE_SINGLE, 6'd0}, ANY_RULE, ANY_RULE,
                    1'b0);
        send(at(2023, 5, 5, 5, 5), tx_gap());
        drain();
        write_rules(ANY_RULE, ANY_RULE, ANY_RULE, {cnms_pkg::MODE_STEP, 6'd0}, ANY_RULE,
                    1'b0);
        send(at(2023, 5, 5, 5, 5), tx_gap());
        drain();
        write_rules(ANY_RULE, ANY_RULE, ANY_RULE, ANY_RULE, {cnms_pkg::MODE_SINGLE, 6'd7},
                    1'b1);
        send(at(2023, 5, 5, 5, 5), tx_gap());
        drain();

        // Feb 29 at midnight: reachable from 2023, beyond the horizon from 2024
        write_rules({cnms_pkg::MODE_SINGLE, 6'd0}, {cnms_pkg::MODE_SINGLE, 6'd0},
                    {cnms_pkg::MODE_SINGLE, 6'd29}, {cnms_pkg::MODE_SINGLE, 6'd2},
                    ANY_RULE, 1'b0);
        send(at(2023, 3, 1, 12, 0), tx_gap());
        send(at(2024, 3, 1, 12, 0), tx_gap());
        drain();

        // Random rule sets, each followed by a burst of random start instants
        for (p = 0; p < RANDOM_PHASES; p++) begin
            tx_max = (p % 4 == 1) ? 0 : 10;
            rx_max = (p % 4 == 1) ? 0 : 10;
            write_rules(rand_rule(0, 59), rand_rule(0, 23), rand_rule(1, 31),
                        rand_rule(1, 12), rand_rule(0, 6), p % 3 == 0);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                send(rand_start(), tx_gap());
                if ($urandom_range(0, 39) == 0) drain();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
